### src/fts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame time statistics package
// Shared types and constants for the frame timing block.
// ----------------------------------------------------------------------------
package fts_pkg;

  localparam logic [62:0] MAX63         = {63{1'b1}};
  localparam logic [63:0] RATE_NUM      = 64'd1_000_000_000_000;
  localparam logic [31:0] MIN_DELTA     = 32'd10;
  localparam logic [31:0] DEF_MAX_DELTA = 32'd100_000_000;
  localparam logic [7:0]  DEF_WINDOW    = 8'd120;
  localparam logic [31:0] DEF_REFRESH   = 32'd250_000_000;
  localparam logic [23:0] DEF_SCALE     = 24'd65536;

  // Dividend widths for the serial divider
  localparam logic [6:0]  RATE_BITS     = 7'd40;
  localparam logic [6:0]  DISP_BITS     = 7'd33;

  // Register indexes
  localparam logic [2:0]  REG_MAX_DELTA = 3'd0;
  localparam logic [2:0]  REG_WINDOW    = 3'd1;
  localparam logic [2:0]  REG_REFRESH   = 3'd2;
  localparam logic [2:0]  REG_SCALE     = 3'd3;
  localparam logic [2:0]  REG_PAUSED    = 3'd4;

  typedef struct packed {
    logic [31:0] max_delta;
    logic [7:0]  window;
    logic [31:0] refresh;
    logic [23:0] scale;
    logic        paused;
  } cfg_t;

  // One classified tick handed from front to back
  typedef struct packed {
    logic        first;
    logic [62:0] frame;
    logic [62:0] raw;
    logic [31:0] clamped;
    logic [62:0] elapsed;
  } item_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
    logic [6:0]  steps;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

### src/fts_channels.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame time statistics channels
// Valid/ready channels for tick words in and statistics words out.
// ----------------------------------------------------------------------------
interface fts_tick_if;
  logic        valid;
  logic        ready;
  logic [62:0] now_ns;
  modport source (output valid, output now_ns, input ready);
  modport sink (input valid, input now_ns, output ready);
endinterface

interface fts_stats_if;
  logic        valid;
  logic        ready;
  logic [62:0] frame_index;
  logic [62:0] raw_delta_ns;
  logic [31:0] clamped_delta_ns;
  logic [39:0] scaled_delta_ns;
  logic [31:0] smooth_delta_ns;
  logic [36:0] instant_rate_mhz;
  logic [36:0] smooth_rate_mhz;
  logic [31:0] display_delta_ns;
  logic [36:0] display_rate_mhz;
  logic [62:0] elapsed_real_ns;
  logic [62:0] unscaled_total_ns;
  logic [62:0] scaled_total_ns;
  modport source (output valid, output frame_index, output raw_delta_ns,
                  output clamped_delta_ns, output scaled_delta_ns,
                  output smooth_delta_ns, output instant_rate_mhz,
                  output smooth_rate_mhz, output display_delta_ns,
                  output display_rate_mhz, output elapsed_real_ns,
                  output unscaled_total_ns, output scaled_total_ns,
                  input ready);
  modport sink (input valid, input frame_index, input raw_delta_ns,
                input clamped_delta_ns, input scaled_delta_ns,
                input smooth_delta_ns, input instant_rate_mhz,
                input smooth_rate_mhz, input display_delta_ns,
                input display_rate_mhz, input elapsed_real_ns,
                input unscaled_total_ns, input scaled_total_ns,
                output ready);
endinterface
`default_nettype wire

### src/fts_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame time statistics front end
// Accepts tick words, measures raw and clamped delta and elapsed time.
// ----------------------------------------------------------------------------
module fts_front (
  input  logic           clk,
  input  logic           rst,
  fts_tick_if.sink       tick,
  input  fts_pkg::cfg_t  cfg,
  input  logic           full,
  output logic           push,
  output fts_pkg::item_t item
);

  logic        started;
  logic [62:0] start_stamp;
  logic [62:0] last_stamp;
  logic [62:0] frame_count;
  logic [62:0] raw;
  logic [62:0] elapsed;
  logic [31:0] maxd;

  assign tick.ready = ~full;
  assign push       = tick.valid & ~full;

  // Measure the tick against the stored stamps
  always_comb begin
    raw     = (tick.now_ns >= last_stamp) ? tick.now_ns - last_stamp : '0;
    elapsed = (tick.now_ns >= start_stamp) ? tick.now_ns - start_stamp : '0;
    maxd    = (cfg.max_delta == '0) ? fts_pkg::DEF_MAX_DELTA : cfg.max_delta;
    item.first = ~started;
    if (started) begin
      item.frame   = (frame_count == fts_pkg::MAX63) ? frame_count : frame_count + 63'd1;
      item.raw     = raw;
      item.clamped = (raw > {31'd0, maxd}) ? maxd : raw[31:0];
      item.elapsed = elapsed;
    end else begin
      item.frame   = 63'd1;
      item.raw     = '0;
      item.clamped = '0;
      item.elapsed = '0;
    end
  end

  // Advance the stamps on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      started     <= 1'b0;
      frame_count <= '0;
    end else if (push) begin
      started     <= 1'b1;
      frame_count <= item.frame;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      last_stamp <= tick.now_ns;
      if (!started) begin
        start_stamp <= tick.now_ns;
      end
    end
  end

endmodule
`default_nettype wire

### src/fts_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame time statistics queue
// Two-entry queue of classified ticks between front and back.
// ----------------------------------------------------------------------------
module fts_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fts_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output fts_pkg::item_t pop_item,
  output logic           empty
);

  fts_pkg::item_t slots [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_item = slots[rptr];

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      priority if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

### src/fts_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame time statistics divider
// Restoring divider, one quotient bit per cycle over the given dividend width.
// ----------------------------------------------------------------------------
module fts_div (
  input  logic              clk,
  input  logic              rst,
  input  fts_pkg::div_req_t req,
  output fts_pkg::div_rsp_t rsp
);

  logic [63:0] rem;
  logic [63:0] dq;
  logic [63:0] divisor;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [64:0] trial;
  logic        fits;

  assign trial    = {rem, dq[63]};
  assign fits     = trial >= {1'b0, divisor};
  assign rsp.done = done;
  assign rsp.quot = dq;

  // Shift in one dividend bit and subtract where it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      dq      <= req.dividend << (7'd64 - req.steps);
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= fits ? 64'(trial - {1'b0, divisor}) : trial[63:0];
      dq  <= {dq[62:0], fits};
    end
  end

endmodule
`default_nettype wire

### src/fts_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame time statistics back end
// Runs the delta window, totals, refresh logic and divisions per later tick.
// ----------------------------------------------------------------------------
module fts_back #(
  parameter int WINDOW_MAX = 128
) (
  input  logic           clk,
  input  logic           rst,
  input  fts_pkg::cfg_t  cfg,
  input  logic           empty,
  input  fts_pkg::item_t qitem,
  output logic           pop,
  fts_stats_if.source    stats
);

  localparam int HW    = $clog2(WINDOW_MAX);
  localparam int FW    = $clog2(WINDOW_MAX + 1);
  localparam int OW    = FW + 1;
  localparam int EW    = (FW > 8) ? FW : 8;
  localparam int SUM_W = 32 + FW;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHK   = 8'b0000_0010,
    S_SUB   = 8'b0000_0100,
    S_PUSH  = 8'b0000_1000,
    S_SUMS  = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_DWAIT = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  typedef enum logic [2:0] {
    OP_RAW, OP_SMOOTH, OP_SRATE, OP_DISP, OP_DRATE
  } op_t;

  state_t            state;
  op_t               op;
  fts_pkg::item_t    cur;
  logic              pushed;
  logic [31:0]       ring [WINDOW_MAX];
  logic [31:0]       rdata;
  logic [HW-1:0]     head;
  logic [FW-1:0]     fill;
  logic [SUM_W-1:0]  sum;
  logic [32:0]       acc;
  logic [31:0]       facc;
  logic [31:0]       disp;
  logic [36:0]       drate;
  logic [62:0]       unsc;
  logic [62:0]       ssum;
  logic [39:0]       scaled;
  logic [31:0]       smooth;
  logic [36:0]       irate;
  logic [36:0]       srate;

  logic [OW-1:0]     old_raw;
  logic [HW-1:0]     oldest;
  logic [HW:0]       head_inc;
  logic [EW-1:0]     win_ext;
  logic [EW-1:0]     eff;
  logic              need_evict;
  logic [31:0]       refresh;
  logic [23:0]       scale;
  logic [55:0]       product;
  logic [63:0]       unsc_add;
  logic [63:0]       ssum_add;
  logic              go;
  logic              load_out;
  fts_pkg::div_req_t req;
  fts_pkg::div_rsp_t rsp;

  fts_div u_div (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Ring addressing and window limits
  always_comb begin
    old_raw  = OW'(head) + OW'(WINDOW_MAX) - OW'(fill);
    if (old_raw >= OW'(WINDOW_MAX)) begin
      old_raw = old_raw - OW'(WINDOW_MAX);
    end
    oldest   = old_raw[HW-1:0];
    head_inc = (HW + 1)'(head) + (HW + 1)'(1);
    win_ext  = EW'((cfg.window == '0) ? fts_pkg::DEF_WINDOW : cfg.window);
    eff      = (win_ext > EW'(WINDOW_MAX)) ? EW'(WINDOW_MAX) : win_ext;
    need_evict = pushed ? (EW'(fill) > eff) : (fill == FW'(WINDOW_MAX));
    refresh  = (cfg.refresh == '0) ? fts_pkg::DEF_REFRESH : cfg.refresh;
    scale    = cfg.paused ? '0 : cfg.scale;
    product  = cur.clamped * scale;
    unsc_add = {1'b0, unsc} + 64'(cur.clamped);
    ssum_add = {1'b0, ssum} + 64'(scaled);
  end

  // Select operands for the next division
  always_comb begin
    req = '0;
    go  = 1'b0;
    unique case (op)
      OP_RAW: begin
        go           = cur.raw > 63'(fts_pkg::MIN_DELTA);
        req.dividend = fts_pkg::RATE_NUM;
        req.divisor  = {1'b0, cur.raw};
        req.steps    = fts_pkg::RATE_BITS;
      end
      OP_SMOOTH: begin
        go           = 1'b1;
        req.dividend = 64'(sum);
        req.divisor  = 64'(fill);
        req.steps    = 7'(SUM_W);
      end
      OP_SRATE: begin
        go           = smooth > fts_pkg::MIN_DELTA;
        req.dividend = fts_pkg::RATE_NUM;
        req.divisor  = 64'(smooth);
        req.steps    = fts_pkg::RATE_BITS;
      end
      OP_DISP: begin
        go           = acc >= {1'b0, refresh};
        req.dividend = 64'(acc);
        req.divisor  = 64'(facc);
        req.steps    = fts_pkg::DISP_BITS;
      end
      OP_DRATE: begin
        go           = disp > fts_pkg::MIN_DELTA;
        req.dividend = fts_pkg::RATE_NUM;
        req.divisor  = 64'(disp);
        req.steps    = fts_pkg::RATE_BITS;
      end
      default: begin
        go = 1'b0;
      end
    endcase
    req.start = (state == S_DIV) && go;
  end

  assign pop      = (state == S_IDLE) && !empty;
  assign load_out = (state == S_OUT) && (!stats.valid || stats.ready);

  // Sequence one tick through window, totals and divisions
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      op     <= OP_RAW;
      pushed <= 1'b0;
      head   <= '0;
      fill   <= '0;
      sum    <= '0;
      acc    <= '0;
      facc   <= '0;
      disp   <= '0;
      drate  <= '0;
      unsc   <= '0;
      ssum   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!empty) begin
            pushed <= 1'b0;
            op     <= OP_RAW;
            state  <= qitem.first ? S_OUT : S_CHK;
          end
        end
        S_CHK: begin
          priority if (need_evict) begin
            state <= S_SUB;
          end else if (!pushed) begin
            state <= S_PUSH;
          end else begin
            state <= S_DIV;
          end
        end
        S_SUB: begin
          sum   <= sum - SUM_W'(rdata);
          fill  <= fill - FW'(1);
          state <= S_CHK;
        end
        S_PUSH: begin
          head   <= (head_inc >= (HW + 1)'(WINDOW_MAX)) ? '0 : head_inc[HW-1:0];
          fill   <= fill + FW'(1);
          sum    <= sum + SUM_W'(cur.clamped);
          acc    <= acc + 33'(cur.clamped);
          facc   <= (facc == '1) ? facc : facc + 32'd1;
          pushed <= 1'b1;
          state  <= S_SUMS;
        end
        S_SUMS: begin
          unsc  <= unsc_add[63] ? fts_pkg::MAX63 : unsc_add[62:0];
          ssum  <= ssum_add[63] ? fts_pkg::MAX63 : ssum_add[62:0];
          state <= S_CHK;
        end
        S_DIV: begin
          if (go) begin
            state <= S_DWAIT;
          end else begin
            unique case (op)
              OP_RAW:   op <= OP_SMOOTH;
              OP_SRATE: op <= OP_DISP;
              OP_DRATE: begin
                drate <= '0;
                state <= S_OUT;
              end
              default:  state <= S_OUT;
            endcase
          end
        end
        S_DWAIT: begin
          if (rsp.done) begin
            state <= S_DIV;
            unique case (op)
              OP_RAW:    op <= OP_SMOOTH;
              OP_SMOOTH: op <= OP_SRATE;
              OP_SRATE:  op <= OP_DISP;
              OP_DISP: begin
                disp <= rsp.quot[31:0];
                acc  <= '0;
                facc <= '0;
                op   <= OP_DRATE;
              end
              default: begin
                drate <= rsp.quot[36:0];
                state <= S_OUT;
              end
            endcase
          end
        end
        S_OUT: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Hold the tick and the per-tick results
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= qitem;
    end
    if (state == S_PUSH) begin
      scaled <= product[55:16];
    end
    if (state == S_DIV && !go && op == OP_RAW) begin
      irate <= '0;
    end
    if (state == S_DIV && !go && op == OP_SRATE) begin
      srate <= '0;
    end
    if (state == S_DWAIT && rsp.done) begin
      if (op == OP_RAW) begin
        irate <= rsp.quot[36:0];
      end
      if (op == OP_SMOOTH) begin
        smooth <= rsp.quot[31:0];
      end
      if (op == OP_SRATE) begin
        srate <= rsp.quot[36:0];
      end
    end
  end

  // Ring memory: write at head, registered read of the oldest entry
  always_ff @(posedge clk) begin
    if (state == S_PUSH) begin
      ring[head] <= cur.clamped;
    end
    if (state == S_CHK && need_evict) begin
      rdata <= ring[oldest];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      stats.valid <= 1'b0;
    end else if (load_out) begin
      stats.valid <= 1'b1;
    end else if (stats.ready) begin
      stats.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      stats.frame_index       <= cur.frame;
      stats.raw_delta_ns      <= cur.raw;
      stats.clamped_delta_ns  <= cur.clamped;
      stats.scaled_delta_ns   <= cur.first ? '0 : scaled;
      stats.smooth_delta_ns   <= cur.first ? '0 : smooth;
      stats.instant_rate_mhz  <= cur.first ? '0 : irate;
      stats.smooth_rate_mhz   <= cur.first ? '0 : srate;
      stats.display_delta_ns  <= disp;
      stats.display_rate_mhz  <= drate;
      stats.elapsed_real_ns   <= cur.elapsed;
      stats.unscaled_total_ns <= cur.first ? '0 : unsc;
      stats.scaled_total_ns   <= cur.first ? '0 : ssum;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(WINDOW_MAX))
    else $error("window fill above ring depth");

  a_push_sum: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH) |=> (fill != '0) && (sum >= SUM_W'(cur.clamped)))
    else $error("window sum lost the pushed delta");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (state == S_DWAIT))
    else $error("divider finished outside a wait");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    load_out |=> stats.valid && (state == S_IDLE))
    else $error("result word not presented");

endmodule
`default_nettype wire

### src/frame_time_statistics_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame time statistics
// Frame tick timing: deltas, smoothed and display rates, and running totals.
// ----------------------------------------------------------------------------
// Each tick word on tick yields one statistics word on stats. The front end
// takes a tick and queues it in a two-entry queue; the back end then works
// on one tick at a time. The first tick after reset goes straight to the
// output register in the back end. A later tick passes the window check,
// ring drops, push and totals, then up to five serial divisions on the
// shared divider, one quotient bit per cycle (40 bits per rate, 32+log2
// of WINDOW_MAX+1 for the smoothed delta, 33 for the display delta); a
// division whose check fails is skipped. Ring depth is WINDOW_MAX.
// ----------------------------------------------------------------------------
module frame_time_statistics_top #(
  parameter int WINDOW_MAX = 128
) (
  input  logic        clk,
  input  logic        rst,
  fts_tick_if.sink    tick,
  fts_stats_if.source stats,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data
);

  fts_pkg::cfg_t  cfg;
  fts_pkg::item_t push_item;
  fts_pkg::item_t pop_item;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_delta <= fts_pkg::DEF_MAX_DELTA;
      cfg.window    <= fts_pkg::DEF_WINDOW;
      cfg.refresh   <= fts_pkg::DEF_REFRESH;
      cfg.scale     <= fts_pkg::DEF_SCALE;
      cfg.paused    <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        fts_pkg::REG_MAX_DELTA: cfg.max_delta <= wr_data;
        fts_pkg::REG_WINDOW:    cfg.window    <= wr_data[7:0];
        fts_pkg::REG_REFRESH:   cfg.refresh   <= wr_data;
        fts_pkg::REG_SCALE:     cfg.scale     <= wr_data[23:0];
        fts_pkg::REG_PAUSED:    cfg.paused    <= wr_data[0];
        default: ;
      endcase
    end
  end

  fts_front u_front (
    .clk  (clk),
    .rst  (rst),
    .tick (tick),
    .cfg  (cfg),
    .full (full),
    .push (push),
    .item (push_item)
  );

  fts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (empty)
  );

  fts_back #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .empty (empty),
    .qitem (pop_item),
    .pop   (pop),
    .stats (stats)
  );

endmodule
`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame time statistics testbench
// Sends timestamp ticks through the tick channel under random source gaps
// and sink stalls, and rewrites registers between phases while idle.
// A scoreboard predicts each statistics word and checks it field by field.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          RING_DEPTH   = 128;
  localparam int          PEND_DEPTH   = 4096;
  localparam logic [2:0]  REG_UNUSED   = 3'd7;
  localparam int          PHASES       = 12;
  localparam int          PHASE_TICKS  = 100;
  localparam int          DRAIN_CYCLES = 600;
  localparam int          STALL_LIMIT  = 20000;
  localparam logic [63:0] TOP63        = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [62:0] frame_index;
    logic [62:0] raw_delta_ns;
    logic [31:0] clamped_delta_ns;
    logic [39:0] scaled_delta_ns;
    logic [31:0] smooth_delta_ns;
    logic [36:0] instant_rate_mhz;
    logic [36:0] smooth_rate_mhz;
    logic [31:0] display_delta_ns;
    logic [36:0] display_rate_mhz;
    logic [62:0] elapsed_real_ns;
    logic [62:0] unscaled_total_ns;
    logic [62:0] scaled_total_ns;
  } stats_t;

  // Predicts statistics words from accepted ticks and checks the outputs
  class stats_scoreboard;
    logic [31:0] max_delta;
    logic [7:0]  window;
    logic [31:0] refresh;
    logic [23:0] scale;
    logic        paused;

    bit          started;
    logic [63:0] start_ts, last_ts, frames;
    logic [31:0] ring [RING_DEPTH];
    int          head, fill;
    logic [63:0] win_sum, refresh_acc, held_rate, unscaled_sum, scaled_sum;
    logic [31:0] refresh_frames, held_delta;

    stats_t      pend_buf [PEND_DEPTH];
    int          pend_wr, pend_rd;
    int          mismatches, words_checked, ticks_noted, display_updates;

    function new();
      max_delta = fts_pkg::DEF_MAX_DELTA;
      window    = fts_pkg::DEF_WINDOW;
      refresh   = fts_pkg::DEF_REFRESH;
      scale     = fts_pkg::DEF_SCALE;
      paused    = 1'b0;
      started   = 0;
      start_ts = 0; last_ts = 0; frames = 0;
      head = 0; fill = 0;
      win_sum = 0; refresh_acc = 0; held_rate = 0;
      unscaled_sum = 0; scaled_sum = 0;
      refresh_frames = 0; held_delta = 0;
      pend_wr = 0; pend_rd = 0;
      mismatches = 0; words_checked = 0; ticks_noted = 0; display_updates = 0;
    endfunction

    function int pending();
      return pend_wr - pend_rd;
    endfunction

    function void store_word(stats_t w);
      pend_buf[pend_wr % PEND_DEPTH] = w;
      pend_wr++;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        fts_pkg::REG_MAX_DELTA: max_delta = data;
        fts_pkg::REG_WINDOW:    window    = data[7:0];
        fts_pkg::REG_REFRESH:   refresh   = data;
        fts_pkg::REG_SCALE:     scale     = data[23:0];
        fts_pkg::REG_PAUSED:    paused    = data[0];
        default: ;
      endcase
    endfunction

    function logic [63:0] mhz_of(logic [63:0] d);
      return (d <= 64'(fts_pkg::MIN_DELTA)) ? 64'd0 : fts_pkg::RATE_NUM / d;
    endfunction

    function logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      return (s > TOP63) ? TOP63 : s;
    endfunction

    function void drop_oldest();
      win_sum -= 64'(ring[(head + RING_DEPTH - fill) % RING_DEPTH]);
      fill--;
    endfunction

    // Advance the predicted state by one tick and queue the expected word
    function void note_tick(logic [62:0] now_ns);
      stats_t      w;
      logic [63:0] now, raw, scaled, smooth, irate, srate;
      logic [31:0] limit, clamped, interval;
      int          win;
      now = 64'(now_ns);
      w = '0;
      ticks_noted++;
      if (!started) begin
        started  = 1;
        start_ts = now;
        last_ts  = now;
        frames   = 1;
        w.frame_index      = 63'd1;
        w.display_delta_ns = held_delta;
        w.display_rate_mhz = held_rate[36:0];
        store_word(w);
        return;
      end
      raw = (now >= last_ts) ? now - last_ts : 64'd0;
      last_ts = now;
      limit = (max_delta == 0) ? fts_pkg::DEF_MAX_DELTA : max_delta;
      clamped = (raw > 64'(limit)) ? limit : raw[31:0];

      // push into the ring, dropping on a full ring and after a shrink
      win = (window == 0) ? int'(fts_pkg::DEF_WINDOW) : int'(window);
      if (win > RING_DEPTH) win = RING_DEPTH;
      if (fill >= RING_DEPTH) drop_oldest();
      ring[head] = clamped;
      head = (head + 1) % RING_DEPTH;
      fill++;
      win_sum += 64'(clamped);
      while (fill > win) drop_oldest();
      smooth = win_sum / 64'(fill);

      scaled = (64'(clamped) * 64'(paused ? 24'd0 : scale)) >> 16;
      if (frames < TOP63) frames++;

      // refresh the held display values once enough time has gathered
      interval = (refresh == 0) ? fts_pkg::DEF_REFRESH : refresh;
      refresh_acc += 64'(clamped);
      if (refresh_frames != 32'hFFFF_FFFF) refresh_frames++;
      if (refresh_acc >= 64'(interval)) begin
        held_delta = 32'(refresh_acc / 64'(refresh_frames));
        held_rate  = mhz_of(64'(held_delta));
        refresh_acc = 0;
        refresh_frames = 0;
        display_updates++;
      end

      unscaled_sum = add_sat(unscaled_sum, 64'(clamped));
      scaled_sum   = add_sat(scaled_sum, scaled);
      irate = mhz_of(raw);
      srate = mhz_of(64'(smooth[31:0]));

      w.frame_index       = frames[62:0];
      w.raw_delta_ns      = raw[62:0];
      w.clamped_delta_ns  = clamped;
      w.scaled_delta_ns   = scaled[39:0];
      w.smooth_delta_ns   = smooth[31:0];
      w.instant_rate_mhz  = irate[36:0];
      w.smooth_rate_mhz   = srate[36:0];
      w.display_delta_ns  = held_delta;
      w.display_rate_mhz  = held_rate[36:0];
      w.elapsed_real_ns   = (now >= start_ts) ? 63'(now - start_ts) : 63'd0;
      w.unscaled_total_ns = unscaled_sum[62:0];
      w.scaled_total_ns   = scaled_sum[62:0];
      store_word(w);
    endfunction

    function void field(string name, logic [63:0] exp_v, logic [63:0] got_v,
                        ref bit bad);
      if (got_v !== exp_v) begin
        bad = 1;
        if (mismatches < 10)
          $display("  word %0d %s: expected %0d, got %0d",
                   words_checked, name, exp_v, got_v);
      end
    endfunction

    function void check_stats(stats_t got);
      stats_t e;
      bit     bad;
      bad = 0;
      if (pending() == 0) begin
        if (mismatches < 10) $display("unexpected statistics word, frame %0d",
                                      got.frame_index);
        mismatches++;
        return;
      end
      e = pend_buf[pend_rd % PEND_DEPTH];
      pend_rd++;
      field("frame_index", 64'(e.frame_index), 64'(got.frame_index), bad);
      field("raw_delta_ns", 64'(e.raw_delta_ns), 64'(got.raw_delta_ns), bad);
      field("clamped_delta_ns", 64'(e.clamped_delta_ns),
            64'(got.clamped_delta_ns), bad);
      field("scaled_delta_ns", 64'(e.scaled_delta_ns), 64'(got.scaled_delta_ns), bad);
      field("smooth_delta_ns", 64'(e.smooth_delta_ns), 64'(got.smooth_delta_ns), bad);
      field("instant_rate_mhz", 64'(e.instant_rate_mhz),
            64'(got.instant_rate_mhz), bad);
      field("smooth_rate_mhz", 64'(e.smooth_rate_mhz), 64'(got.smooth_rate_mhz), bad);
      field("display_delta_ns", 64'(e.display_delta_ns),
            64'(got.display_delta_ns), bad);
      field("display_rate_mhz", 64'(e.display_rate_mhz),
            64'(got.display_rate_mhz), bad);
      field("elapsed_real_ns", 64'(e.elapsed_real_ns), 64'(got.elapsed_real_ns), bad);
      field("unscaled_total_ns", 64'(e.unscaled_total_ns),
            64'(got.unscaled_total_ns), bad);
      field("scaled_total_ns", 64'(e.scaled_total_ns), 64'(got.scaled_total_ns), bad);
      if (bad) mismatches++;
      words_checked++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        wr_en;
  logic [2:0]  wr_index;
  logic [31:0] wr_data;
  bit          quiet;
  logic [62:0] stamp;
  int          idle_cycles;

  fts_tick_if  tick_ch ();
  fts_stats_if stats_ch ();

  stats_scoreboard sb = new();

  frame_time_statistics_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .tick     (tick_ch),
    .stats    (stats_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always #2 clk = ~clk;

  // Drive each register write until the next edge; the caller drops wr_en
  task automatic put_reg(logic [2:0] idx, logic [31:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Send one tick word after a random gap and wait for acceptance
  task automatic send_tick(logic [62:0] t);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid  <= 1'b1;
    tick_ch.now_ns <= t;
    do @(posedge clk); while (!tick_ch.ready);
    sb.note_tick(t);
  endtask

  // Wait until every expected word has come, then let the back end settle
  task automatic drain();
    tick_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Advance the timestamp by a delta shaped around the current clamp
  function automatic logic [62:0] next_stamp(logic [62:0] cur);
    logic [63:0] lim, d, nxt;
    int          pick;
    lim  = (sb.max_delta == 0) ? 64'(fts_pkg::DEF_MAX_DELTA) : 64'(sb.max_delta);
    pick = $urandom_range(0, 99);
    if (pick < 20)      d = 64'($urandom_range(0, 12));
    else if (pick < 60) d = 64'($urandom) % (lim + 1);
    else if (pick < 75) d = lim + 64'($urandom_range(0, 1000));
    else if (pick < 85) d = {24'd0, 8'($urandom_range(0, 255)), $urandom};
    else begin
      d = 64'($urandom) % (64'(cur) + 1);
      return cur - 63'(d);
    end
    nxt = 64'(cur) + d;
    return (nxt > TOP63) ? 63'($urandom) : nxt[62:0];
  endfunction

  // Accept statistics words with random stalls
  initial begin
    int stall;
    stats_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        stats_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      stats_ch.ready <= 1'b1;
      do @(posedge clk); while (!stats_ch.valid);
      sb.check_stats('{stats_ch.frame_index, stats_ch.raw_delta_ns,
                       stats_ch.clamped_delta_ns, stats_ch.scaled_delta_ns,
                       stats_ch.smooth_delta_ns, stats_ch.instant_rate_mhz,
                       stats_ch.smooth_rate_mhz, stats_ch.display_delta_ns,
                       stats_ch.display_rate_mhz, stats_ch.elapsed_real_ns,
                       stats_ch.unscaled_total_ns, stats_ch.scaled_total_ns});
    end
  end

  // Count cycles with no word moving on either side
  always @(posedge clk) begin
    if ((tick_ch.valid && tick_ch.ready) || (stats_ch.valid && stats_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    idle_cycles     = 0;
    quiet           = 0;
    rst            <= 1'b1;
    wr_en          <= 1'b0;
    wr_index       <= fts_pkg::REG_MAX_DELTA;
    wr_data        <= '0;
    tick_ch.valid  <= 1'b0;
    tick_ch.now_ns <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: first tick, extreme stamps, backwards time, tiny deltas
    send_tick(63'd1000);
    send_tick(63'd1000);
    send_tick(63'd1010);
    send_tick(63'd1021);
    send_tick(fts_pkg::MAX63);
    send_tick(63'd0);
    send_tick(63'd5);
    send_tick(63'd200_000_000);
    for (int i = 0; i < 14; i++) send_tick(63'd200_000_000 + 63'(i) * 63'd16_666_667);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      quiet = (p % 4 == 3);
      case (p)
        0: begin
          put_reg(fts_pkg::REG_MAX_DELTA, 32'd0);
          put_reg(fts_pkg::REG_WINDOW, 32'd0);
          put_reg(fts_pkg::REG_REFRESH, 32'd0);
          put_reg(fts_pkg::REG_SCALE, 32'd0);
          put_reg(fts_pkg::REG_PAUSED, 32'd0);
        end
        1: begin
          put_reg(fts_pkg::REG_MAX_DELTA, 32'hFFFF_FFFF);
          put_reg(fts_pkg::REG_WINDOW, 32'd128);
          put_reg(fts_pkg::REG_REFRESH, 32'hFFFF_FFFF);
          put_reg(fts_pkg::REG_SCALE, 32'h00FF_FFFF);
          put_reg(fts_pkg::REG_PAUSED, 32'd1);
        end
        2: begin
          put_reg(fts_pkg::REG_MAX_DELTA, 32'd1);
          put_reg(fts_pkg::REG_WINDOW, 32'd1);
          put_reg(fts_pkg::REG_REFRESH, 32'd1);
          put_reg(fts_pkg::REG_SCALE, 32'd1);
          put_reg(fts_pkg::REG_PAUSED, 32'd0);
        end
        3: begin
          put_reg(fts_pkg::REG_WINDOW, 32'd255);
          put_reg(fts_pkg::REG_MAX_DELTA, 32'd50_000);
          put_reg(REG_UNUSED, $urandom);
        end
        default: begin
          put_reg(fts_pkg::REG_MAX_DELTA, ($urandom_range(0, 3) == 0) ? $urandom
                                          : $urandom_range(1, 40_000_000));
          put_reg(fts_pkg::REG_WINDOW, $urandom_range(0, 255));
          put_reg(fts_pkg::REG_REFRESH, $urandom_range(1, 100_000_000));
          put_reg(fts_pkg::REG_SCALE, {8'd0, 24'($urandom)});
          put_reg(fts_pkg::REG_PAUSED, 32'($urandom_range(0, 3) == 0));
        end
      endcase
      wr_en <= 1'b0;
      @(posedge clk);
      stamp = sb.last_ts[62:0];
      for (int i = 0; i < PHASE_TICKS; i++) begin
        stamp = next_stamp(stamp);
        send_tick(stamp);
      end
      drain();
    end

    $display("%0d ticks sent over %0d register settings, %0d words checked,",
             sb.ticks_noted, PHASES + 1, sb.words_checked);
    $display("%0d display refreshes, %0d words wrong", sb.display_updates,
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
src/fts_pkg.sv
src/fts_channels.sv
src/fts_front.sv
src/fts_queue.sv
src/fts_div.sv
src/fts_back.sv
src/frame_time_statistics_top.sv
dv/testbench.sv
